@@ rtl/core/qptm_pkg.sv @@
// ----------------------------------------------------------------------------
// qptm_pkg
// Shared widths, stage bundle and the rounding helper for the quaternion
// pose to matrix pipeline.
// ----------------------------------------------------------------------------
package qptm_pkg;

    localparam int unsigned QUAT_W  = 16;
    localparam int unsigned TRANS_W = 32;
    localparam int unsigned PROD_W  = 2 * QUAT_W;
    localparam int unsigned ACC_W   = PROD_W + 2;
    localparam int unsigned ROT_W   = 18;
    localparam int unsigned FRAC_W  = 15;

    localparam int unsigned IN_DATA_W  = 4 * QUAT_W + 3 * TRANS_W;
    localparam int unsigned OUT_BITS   = 9 * ROT_W + 3 * TRANS_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [ROT_W+1:0] ROT_MAX = 20'sd131071;
    localparam logic signed [ROT_W+1:0] ROT_MIN = -20'sd131072;

    // products of the quaternion components plus the translation, one beat
    typedef struct packed {
        logic signed [PROD_W-1:0]  ww;
        logic signed [PROD_W-1:0]  xx;
        logic signed [PROD_W-1:0]  yy;
        logic signed [PROD_W-1:0]  zz;
        logic signed [PROD_W-1:0]  wx;
        logic signed [PROD_W-1:0]  wy;
        logic signed [PROD_W-1:0]  wz;
        logic signed [PROD_W-1:0]  xy;
        logic signed [PROD_W-1:0]  xz;
        logic signed [PROD_W-1:0]  yz;
        logic signed [TRANS_W-1:0] tx;
        logic signed [TRANS_W-1:0] ty;
        logic signed [TRANS_W-1:0] tz;
    } t_prod;

    // q4.30 sum to q3.15: round half up, then clamp to 18 bits
    function automatic logic [ROT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]     t;
        logic signed [ROT_W+1:0]   q;
        logic        [ROT_W-1:0]   res;
        t = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_W - 1));
        q = t[ACC_W:FRAC_W];
        if (q > ROT_MAX) begin
            res = ROT_MAX[ROT_W-1:0];
        end else if (q < ROT_MIN) begin
            res = ROT_MIN[ROT_W-1:0];
        end else begin
            res = q[ROT_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/qptm_mul_stage.sv @@
// ----------------------------------------------------------------------------
// qptm_mul_stage
// First pipeline stage: the ten component products, registered with the
// translation, with its own valid bit and backpressure.
// ----------------------------------------------------------------------------
module qptm_mul_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [qptm_pkg::QUAT_W-1:0]  i_quat_w,
    input  logic signed [qptm_pkg::QUAT_W-1:0]  i_quat_x,
    input  logic signed [qptm_pkg::QUAT_W-1:0]  i_quat_y,
    input  logic signed [qptm_pkg::QUAT_W-1:0]  i_quat_z,
    input  logic signed [qptm_pkg::TRANS_W-1:0] i_trans_x,
    input  logic signed [qptm_pkg::TRANS_W-1:0] i_trans_y,
    input  logic signed [qptm_pkg::TRANS_W-1:0] i_trans_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output qptm_pkg::t_prod                     o_prod
);

    logic            r_valid;
    qptm_pkg::t_prod r_prod;
    qptm_pkg::t_prod n_prod;

    // stage takes a beat when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // one multiplier per product
    always_comb begin
        n_prod.ww = i_quat_w * i_quat_w;
        n_prod.xx = i_quat_x * i_quat_x;
        n_prod.yy = i_quat_y * i_quat_y;
        n_prod.zz = i_quat_z * i_quat_z;
        n_prod.wx = i_quat_w * i_quat_x;
        n_prod.wy = i_quat_w * i_quat_y;
        n_prod.wz = i_quat_w * i_quat_z;
        n_prod.xy = i_quat_x * i_quat_y;
        n_prod.xz = i_quat_x * i_quat_z;
        n_prod.yz = i_quat_y * i_quat_z;
        n_prod.tx = i_trans_x;
        n_prod.ty = i_trans_y;
        n_prod.tz = i_trans_z;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

@@ rtl/core/quaternion_pose_to_matrix.sv @@
// ----------------------------------------------------------------------------
// quaternion_pose_to_matrix
// Rotation quaternion and translation to a 3x4 affine pose matrix.
// Stages in order: multiply, sum, round/clamp, each with its own register.
// Throughput is one beat per cycle while the receiver does not stall m_tready.
// Each stage fills its own bubble, so stalls lose and repeat nothing.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module quaternion_pose_to_matrix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // quat_w, quat_x, quat_y, quat_z (16 each), trans_x, trans_y, trans_z (32 each)
    input  logic [qptm_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // rot_r0c0..rot_r2c2 (18 each, row-major), col_x, col_y, col_z (32 each), zero pad
    output logic [qptm_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int unsigned QW = qptm_pkg::QUAT_W;
    localparam int unsigned TW = qptm_pkg::TRANS_W;
    localparam int unsigned AW = qptm_pkg::ACC_W;
    localparam int unsigned RW = qptm_pkg::ROT_W;
    localparam int unsigned PW = qptm_pkg::PROD_W;

    logic            s1_valid;
    logic            s1_ready;
    qptm_pkg::t_prod s1_prod;

    logic                 r_v2;
    logic signed [AW-1:0] r_acc [9];
    logic signed [AW-1:0] n_acc [9];
    logic [TW-1:0]        r_t2  [3];

    logic                 r_v3;
    logic [RW-1:0]        r_rot [9];
    logic [TW-1:0]        r_t3  [3];

    logic rd2;
    logic rd3;

    // stage one: products
    qptm_mul_stage u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_quat_w  (s_tdata[QW-1:0]),
        .i_quat_x  (s_tdata[2*QW-1:QW]),
        .i_quat_y  (s_tdata[3*QW-1:2*QW]),
        .i_quat_z  (s_tdata[4*QW-1:3*QW]),
        .i_trans_x (s_tdata[4*QW+TW-1:4*QW]),
        .i_trans_y (s_tdata[4*QW+2*TW-1:4*QW+TW]),
        .i_trans_z (s_tdata[4*QW+3*TW-1:4*QW+2*TW]),
        .o_valid   (s1_valid),
        .i_ready   (s1_ready),
        .o_prod    (s1_prod)
    );

    // stage readiness back from the output
    assign rd3      = !r_v3 || m_tready;
    assign rd2      = !r_v2 || rd3;
    assign s1_ready = rd2;

    // stage two: exact sums of squares and doubled cross products
    always_comb begin
        logic signed [AW-1:0] ww, xx, yy, zz, wx2, wy2, wz2, xy2, xz2, yz2;
        ww  = {{2{s1_prod.ww[PW-1]}}, s1_prod.ww};
        xx  = {{2{s1_prod.xx[PW-1]}}, s1_prod.xx};
        yy  = {{2{s1_prod.yy[PW-1]}}, s1_prod.yy};
        zz  = {{2{s1_prod.zz[PW-1]}}, s1_prod.zz};
        wx2 = {s1_prod.wx[PW-1], s1_prod.wx, 1'b0};
        wy2 = {s1_prod.wy[PW-1], s1_prod.wy, 1'b0};
        wz2 = {s1_prod.wz[PW-1], s1_prod.wz, 1'b0};
        xy2 = {s1_prod.xy[PW-1], s1_prod.xy, 1'b0};
        xz2 = {s1_prod.xz[PW-1], s1_prod.xz, 1'b0};
        yz2 = {s1_prod.yz[PW-1], s1_prod.yz, 1'b0};
        n_acc[0] = ww + xx - yy - zz;
        n_acc[1] = xy2 - wz2;
        n_acc[2] = xz2 + wy2;
        n_acc[3] = xy2 + wz2;
        n_acc[4] = ww - xx + yy - zz;
        n_acc[5] = yz2 - wx2;
        n_acc[6] = xz2 - wy2;
        n_acc[7] = yz2 + wx2;
        n_acc[8] = ww - xx - yy + zz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rd2) begin
            r_v2 <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd2 && s1_valid) begin
            r_acc   <= n_acc;
            r_t2[0] <= s1_prod.tx;
            r_t2[1] <= s1_prod.ty;
            r_t2[2] <= s1_prod.tz;
        end
    end

    // stage three: round half up and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rd3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd3 && r_v2) begin
            for (int i = 0; i < 9; i++) begin
                r_rot[i] <= qptm_pkg::round_sat(r_acc[i]);
            end
            r_t3 <= r_t2;
        end
    end

    // output beat packing
    assign m_tvalid = r_v3;
    assign m_tdata  = {{(qptm_pkg::OUT_DATA_W - qptm_pkg::OUT_BITS){1'b0}},
                       r_t3[2], r_t3[1], r_t3[0],
                       r_rot[8], r_rot[7], r_rot[6], r_rot[5], r_rot[4],
                       r_rot[3], r_rot[2], r_rot[1], r_rot[0]};

    // no beat enters when every stage is full and the output is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && r_v2 && r_v3 && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline is full");

    // a stalled middle stage keeps its sums
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !m_tready) |=> (r_v2 && $stable(r_acc[0]) && $stable(r_t2[0])))
        else $error("stage two changed while stalled");

    // a beat in stage two reaches the output on the next free cycle
    a_s2_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rd3) |=> r_v3)
        else $error("stage two beat lost");

    // an empty pipeline cannot present an output
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v2 && (!r_v3 || m_tready)) |=> !m_tvalid)
        else $error("output beat without a source");

endmodule

@@ tb/sv/tb_quaternion_pose_to_matrix.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_pose_to_matrix
// Streams quaternion/translation beats into the pose matrix pipeline under
// random sender gaps and receiver stalls, predicts each 3x4 matrix in the
// bench and checks every output beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_quaternion_pose_to_matrix;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAD_W       = qptm_pkg::OUT_DATA_W - qptm_pkg::OUT_BITS;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_POSES = 450;

    // input beat, lowest field last
    typedef struct packed {
        logic signed [qptm_pkg::TRANS_W-1:0] trans_z;
        logic signed [qptm_pkg::TRANS_W-1:0] trans_y;
        logic signed [qptm_pkg::TRANS_W-1:0] trans_x;
        logic signed [qptm_pkg::QUAT_W-1:0]  quat_z;
        logic signed [qptm_pkg::QUAT_W-1:0]  quat_y;
        logic signed [qptm_pkg::QUAT_W-1:0]  quat_x;
        logic signed [qptm_pkg::QUAT_W-1:0]  quat_w;
    } pose_t;

    // output beat, rot[0] is r0c0 in the lowest bits, row-major
    typedef struct packed {
        logic [PAD_W-1:0]                    pad;
        logic [qptm_pkg::TRANS_W-1:0]        col_z;
        logic [qptm_pkg::TRANS_W-1:0]        col_y;
        logic [qptm_pkg::TRANS_W-1:0]        col_x;
        logic [8:0][qptm_pkg::ROT_W-1:0]     rot;
    } matrix_t;

    // ------------------------------------------------------------------------
    // matrix predictor and in-order checker
    // ------------------------------------------------------------------------
    class pose_matrix_board;
        matrix_t expected_matrices[$];
        int      mismatch_count;
        int      printed_lines;

        function new();
            mismatch_count = 0;
            printed_lines  = 0;
        endfunction

        // q4.30 sum to q3.15 with round half up and clamp to 18 bits
        function logic [qptm_pkg::ROT_W-1:0] round_clamp(longint acc);
            longint t;
            longint q;
            t = acc + 64'sd16384;
            q = t >>> 15;
            if (q > 64'sd131071)
                q = 64'sd131071;
            if (q < -64'sd131072)
                q = -64'sd131072;
            return q[qptm_pkg::ROT_W-1:0];
        endfunction

        function matrix_t predict_matrix(pose_t p);
            longint  w, x, y, z;
            longint  ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
            matrix_t m;
            w  = longint'(p.quat_w);
            x  = longint'(p.quat_x);
            y  = longint'(p.quat_y);
            z  = longint'(p.quat_z);
            ww = w * w;
            xx = x * x;
            yy = y * y;
            zz = z * z;
            wx = 2 * w * x;
            wy = 2 * w * y;
            wz = 2 * w * z;
            xy = 2 * x * y;
            xz = 2 * x * z;
            yz = 2 * y * z;
            m.rot[0] = round_clamp(ww + xx - yy - zz);
            m.rot[1] = round_clamp(xy - wz);
            m.rot[2] = round_clamp(xz + wy);
            m.rot[3] = round_clamp(xy + wz);
            m.rot[4] = round_clamp(ww - xx + yy - zz);
            m.rot[5] = round_clamp(yz - wx);
            m.rot[6] = round_clamp(xz - wy);
            m.rot[7] = round_clamp(yz + wx);
            m.rot[8] = round_clamp(ww - xx - yy + zz);
            m.col_x  = p.trans_x;
            m.col_y  = p.trans_y;
            m.col_z  = p.trans_z;
            m.pad    = '0;
            return m;
        endfunction

        function void note_pose(pose_t p);
            expected_matrices.push_back(predict_matrix(p));
        endfunction

        function int pending();
            return expected_matrices.size();
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (printed_lines < 60) begin
                $display("mismatch: %s", msg);
                printed_lines++;
            end
        endtask

        task check_matrix(matrix_t got);
            matrix_t want;
            if (expected_matrices.size() == 0) begin
                report_mismatch("output beat with no pose waiting");
            end else begin
                want = expected_matrices.pop_front();
                for (int r = 0; r < 9; r++) begin
                    if (got.rot[r] !== want.rot[r])
                        report_mismatch($sformatf("rot_r%0dc%0d got %h want %h",
                                        r / 3, r % 3, got.rot[r], want.rot[r]));
                end
                if (got.col_x !== want.col_x)
                    report_mismatch($sformatf("col_x got %h want %h", got.col_x, want.col_x));
                if (got.col_y !== want.col_y)
                    report_mismatch($sformatf("col_y got %h want %h", got.col_y, want.col_y));
                if (got.col_z !== want.col_z)
                    report_mismatch($sformatf("col_z got %h want %h", got.col_z, want.col_z));
                if (got.pad !== want.pad)
                    report_mismatch($sformatf("pad bits got %h", got.pad));
            end
        endtask
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    // quat_w, quat_x, quat_y, quat_z (16 each), trans_x, trans_y, trans_z (32 each)
    logic [qptm_pkg::IN_DATA_W-1:0]      s_tdata;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // rot_r0c0..rot_r2c2 (18 each), col_x, col_y, col_z (32 each), zero pad
    logic [qptm_pkg::OUT_DATA_W-1:0]     m_tdata;

    pose_matrix_board board;
    int               cycle_count = 0;
    int               burst_left;
    int               stall_mode = 0;
    int               stall_left = 0;

    quaternion_pose_to_matrix DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // beat monitors on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            board.note_pose(pose_t'(s_tdata));
        if (i_rst_n && m_tvalid && m_tready)
            board.check_matrix(matrix_t'(m_tdata));
    end

    // receiver stall pattern: free-running, random, heavy and periodic phases
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycle_count % 7) < 4);
        endcase
    end

    // one beat on the slave side, with burst gaps in front of it
    task automatic push_pose(input pose_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // hold the sender off until every matrix has come back
    task automatic drain_matrices();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    function automatic logic [15:0] corner_component();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return 16'h7FFF;
            default: return 16'h5A82;
        endcase
    endfunction

    function automatic logic [31:0] corner_trans();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_trans();
        if ($urandom_range(0, 4) == 0)
            return corner_trans();
        return $urandom();
    endfunction

    // directed poses: identity, -1.0 components, saturation, rounding ties
    function automatic pose_t directed_pose(int k);
        pose_t p;
        logic [15:0] q [4];
        q = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        case (k)
            0:  q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
            1:  q = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
            2:  q = '{16'h8000, 16'h0000, 16'h0000, 16'h0000};
            3:  q = '{16'h0000, 16'h8000, 16'h0000, 16'h0000};
            4:  q = '{16'h0000, 16'h0000, 16'h8000, 16'h0000};
            5:  q = '{16'h0000, 16'h0000, 16'h0000, 16'h8000};
            6:  q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
            7:  q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
            8:  q = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
            9:  q = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
            10: q = '{16'h0000, 16'h0001, 16'h2000, 16'h0000};
            11: q = '{16'h0000, 16'hFFFF, 16'h2000, 16'h0000};
            12: q = '{16'h0000, 16'h0001, 16'h1FFF, 16'h0000};
            13: q = '{16'h5A82, 16'h0000, 16'h0000, 16'h5A82};
            14: q = '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000};
            15: q = '{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF};
            16: q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            17: q = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
            default: q = '{16'h4000, 16'hC000, 16'h4000, 16'hC000};
        endcase
        p.quat_w  = q[0];
        p.quat_x  = q[1];
        p.quat_y  = q[2];
        p.quat_z  = q[3];
        case (k % 5)
            0: begin
                p.trans_x = 32'h8000_0000;
                p.trans_y = 32'h7FFF_FFFF;
                p.trans_z = 32'h0000_0000;
            end
            1: begin
                p.trans_x = 32'h7FFF_FFFF;
                p.trans_y = 32'h8000_0000;
                p.trans_z = 32'hFFFF_FFFF;
            end
            2: begin
                p.trans_x = 32'hFFFF_FFFF;
                p.trans_y = 32'h0000_0000;
                p.trans_z = 32'h8000_0000;
            end
            3: begin
                p.trans_x = 32'h0000_0000;
                p.trans_y = 32'hFFFF_FFFF;
                p.trans_z = 32'h7FFF_FFFF;
            end
            default: begin
                p.trans_x = $urandom();
                p.trans_y = $urandom();
                p.trans_z = $urandom();
            end
        endcase
        return p;
    endfunction

    // random pose: near-unit quaternions as the largest share, plus raw, corner and tiny ones
    function automatic pose_t random_pose();
        pose_t p;
        real   a, b, c, d, n;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            a = (real'($urandom_range(0, 65534)) - 32767.0) / 32767.0;
            b = (real'($urandom_range(0, 65534)) - 32767.0) / 32767.0;
            c = (real'($urandom_range(0, 65534)) - 32767.0) / 32767.0;
            d = (real'($urandom_range(0, 65534)) - 32767.0) / 32767.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 0.001) begin
                a = 1.0;
                n = 1.0;
            end
            p.quat_w = 16'($rtoi(a / n * 32767.0));
            p.quat_x = 16'($rtoi(b / n * 32767.0));
            p.quat_y = 16'($rtoi(c / n * 32767.0));
            p.quat_z = 16'($rtoi(d / n * 32767.0));
        end else if (pick < 65) begin
            p.quat_w = 16'($urandom());
            p.quat_x = 16'($urandom());
            p.quat_y = 16'($urandom());
            p.quat_z = 16'($urandom());
        end else if (pick < 85) begin
            p.quat_w = corner_component();
            p.quat_x = corner_component();
            p.quat_y = corner_component();
            p.quat_z = corner_component();
        end else begin
            p.quat_w = 16'(int'($urandom_range(0, 600)) - 300);
            p.quat_x = 16'(int'($urandom_range(0, 600)) - 300);
            p.quat_y = 16'(int'($urandom_range(0, 600)) - 300);
            p.quat_z = 16'(int'($urandom_range(0, 600)) - 300);
        end
        p.trans_x = rand_trans();
        p.trans_y = rand_trans();
        p.trans_z = rand_trans();
        return p;
    endfunction

    // main sequence
    initial begin
        board       = new();
        burst_left  = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 20; k++)
            push_pose(directed_pose(k));
        drain_matrices();

        for (int i = 0; i < RANDOM_POSES; i++) begin
            if (i == RANDOM_POSES / 2)
                drain_matrices();
            push_pose(random_pose());
        end

        // let the last beats out of the three pipeline stages
        drain_matrices();
        repeat (8) @(posedge i_clk);

        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d matrices never came out", board.pending()));
        if (board.mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
